@@ rtl/core/tpsc_pkg.sv @@
// Shared types, widths and codes for the tape pause-search controller.
package tpsc_pkg;

    // Sample and filter widths
    localparam int ADC_BITS  = 10;
    localparam int FRAC_BITS = 8;
    localparam int FL_W      = ADC_BITS + FRAC_BITS;

    // Filter gains in 1/256 units
    localparam int GAIN_W    = 8;
    localparam logic [GAIN_W-1:0] GAIN_FAST = 8'd230;
    localparam logic [GAIN_W-1:0] GAIN_SLOW = 8'd8;

    // Configuration register widths
    localparam int SIL_W      = 10;
    localparam int QUIET_W    = 8;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Common width for level compares (covers any sample width up to 16)
    localparam int CMP_W = 16;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_PULSE  = 3'd2,
        OP_START  = 3'd3,
        OP_CANCEL = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_PLAY    = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_REWIND  = 3'd3,
        CMD_FORWARD = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FIND    = 3'd1,
        PH_COUNT   = 3'd2,
        PH_DECIDE  = 3'd3,
        PH_REVERSE = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SILENCE_LEVEL = 3'd0,
        REG_LOUD_TIME     = 3'd1,
        REG_SILENCE_TIME  = 3'd2,
        REG_SETTLE_TICKS  = 3'd3,
        REG_OVERDO_IGNORE = 3'd4,
        REG_OVERDO_NEAR   = 3'd5,
        REG_OVERDO_MAX    = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]          op;
        logic [ADC_BITS-1:0] adc_value;
        logic                search_reverse;
    } t_in_item;

    typedef struct packed {
        logic [2:0] mode_command;
        logic [2:0] search_phase;
        logic       searching;
    } t_out_item;

endpackage

@@ rtl/core/tpsc_filter.sv @@
// Adaptive exponential filter: one update of the Q(ADC_BITS.FRAC_BITS) level.
module tpsc_filter import tpsc_pkg::*; (
    input  logic [FL_W-1:0]     i_level,
    input  logic [ADC_BITS-1:0] i_adc,
    output logic [FL_W-1:0]     o_level
);

    localparam int PROD_W = FL_W + GAIN_W;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (GAIN_W - 1);

    logic [FL_W-1:0]   x;
    logic              up;
    logic [FL_W-1:0]   mag;
    logic [GAIN_W-1:0] gain;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rounded;
    logic [FL_W-1:0]   step;

    // Sample aligned to the level's fixed point
    assign x   = {i_adc, {FRAC_BITS{1'b0}}};
    assign up  = (x >= i_level);
    assign mag = up ? (x - i_level) : (i_level - x);

    // Fast gain once the integer part of the difference reaches two
    assign gain = (|mag[FL_W-1:FRAC_BITS+1]) ? GAIN_FAST : GAIN_SLOW;

    // Step magnitude, rounded half up; never exceeds the difference
    assign prod    = PROD_W'(mag) * PROD_W'(gain);
    assign rounded = prod + ROUND;
    assign step    = rounded[PROD_W-1:GAIN_W];

    assign o_level = up ? (i_level + step) : (i_level - step);

endmodule

@@ rtl/core/tape_pause_search_controller.sv @@
// Requests pass from the input register to the result register, which drives o_out_item.
// Throughput: one request per cycle while the result channel is not stalled; the two registers
// pipeline back to back, and the whole state update is one pass of logic between them.
// Reset: i_rst_n is synchronous, active low; it empties both registers, clears the search
// state and filter level, and loads the configuration registers with their defaults.
module tape_pause_search_controller import tpsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration
    logic [SIL_W-1:0]   r_silence_level;
    logic [CNT_W-1:0]   r_loud_time;
    logic [QUIET_W-1:0] r_silence_time;
    logic [CNT_W-1:0]   r_settle_ticks;
    logic [CNT_W-1:0]   r_overdo_ignore;
    logic [CNT_W-1:0]   r_overdo_near;
    logic [CNT_W-1:0]   r_overdo_max;

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // Search state
    t_phase             r_phase,  n_phase;
    logic               r_flag,   n_flag;
    logic               r_dir,    n_dir;
    logic [CNT_W-1:0]   r_over,   n_over;
    logic [CNT_W-1:0]   r_settle, n_settle;
    logic [CNT_W-1:0]   r_loud,   n_loud;
    logic [QUIET_W-1:0] r_quiet,  n_quiet;
    logic [FL_W-1:0]    r_level,  n_level;
    t_cmd               n_cmd;

    logic               advance;
    logic               fire;
    logic               in_accept;
    logic [FL_W-1:0]    filt_level;
    logic [CMP_W-1:0]   lvl;
    logic [CMP_W-1:0]   sil;
    logic               lvl_lt;
    logic               lvl_gt;
    logic               steady;
    logic               quiet_done;
    logic [CNT_W-1:0]   settle_inc;
    logic               settle_done;
    logic               over_ignore;
    logic               over_near;

    // Handshake
    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Filter update for the request in the input register
    tpsc_filter u_filter (
        .i_level (r_level),
        .i_adc   (r_in.adc_value),
        .o_level (filt_level)
    );

    // Decision terms
    assign lvl         = CMP_W'(filt_level[FL_W-1:FRAC_BITS]);
    assign sil         = CMP_W'(r_silence_level);
    assign lvl_lt      = (lvl < sil);
    assign lvl_gt      = (lvl > sil);
    assign steady      = (r_loud > r_loud_time);
    assign quiet_done  = (r_quiet >= r_silence_time);
    assign settle_inc  = (r_settle != '1) ? (r_settle + CNT_W'(1)) : r_settle;
    assign settle_done = (settle_inc > r_settle_ticks);
    assign over_ignore = (r_over <= r_overdo_ignore);
    assign over_near   = (r_over <= r_overdo_near);

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_flag   = r_flag;
        n_dir    = r_dir;
        n_over   = r_over;
        n_settle = r_settle;
        n_loud   = r_loud;
        n_quiet  = r_quiet;
        n_level  = r_level;
        if (fire) begin
            unique case (r_in.op)
                OP_TICK: begin
                    if (!r_flag) begin
                        n_phase = PH_IDLE;
                    end else begin
                        unique case (r_phase)
                            PH_IDLE: begin
                                n_settle = '0;
                                n_over   = '0;
                                n_phase  = PH_FIND;
                            end
                            PH_COUNT: begin
                                n_settle = settle_inc;
                                if (settle_done) begin
                                    n_phase = PH_DECIDE;
                                end
                            end
                            PH_DECIDE: begin
                                if (over_ignore) begin
                                    n_flag  = 1'b0;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_REVERSE;
                                end
                            end
                            PH_REVERSE: begin
                                if (over_near) begin
                                    n_flag  = 1'b0;
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                OP_SAMPLE: begin
                    if (r_phase != PH_FIND) begin
                        n_loud  = '0;
                        n_quiet = '0;
                    end else begin
                        n_level = filt_level;
                        priority if (lvl_lt && !steady) begin
                            n_loud  = '0;
                            n_quiet = '0;
                        end else if (lvl_gt && !steady) begin
                            if (r_loud != '1) begin
                                n_loud = r_loud + CNT_W'(1);
                            end
                        end else if (lvl_lt && steady && !quiet_done) begin
                            n_quiet = r_quiet + QUIET_W'(1);
                        end else if (quiet_done) begin
                            n_loud  = '0;
                            n_quiet = '0;
                            n_phase = PH_COUNT;
                        end else begin
                        end
                    end
                end
                OP_PULSE: begin
                    if (r_phase == PH_COUNT && r_over < r_overdo_max) begin
                        n_over = r_over + CNT_W'(1);
                    end
                    if (r_phase == PH_REVERSE && r_over != '0) begin
                        n_over = r_over - CNT_W'(1);
                    end
                end
                OP_START: begin
                    n_flag = 1'b1;
                    n_dir  = r_in.search_reverse;
                end
                OP_CANCEL: begin
                    n_flag = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Command output
    always_comb begin
        n_cmd = CMD_NONE;
        if (r_in.op == OP_TICK && r_flag) begin
            if (r_phase == PH_DECIDE) begin
                if (over_ignore) begin
                    n_cmd = CMD_PLAY;
                end else begin
                    n_cmd = r_dir ? CMD_FORWARD : CMD_REWIND;
                end
            end else if (r_phase == PH_REVERSE && over_near) begin
                n_cmd = CMD_PLAY;
            end
        end else if (r_in.op == OP_SAMPLE && r_phase == PH_FIND) begin
            if (!(lvl_lt && !steady) && !(lvl_gt && !steady)
                && !(lvl_lt && steady && !quiet_done) && quiet_done) begin
                n_cmd = CMD_STOP;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_flag      <= 1'b0;
            r_dir       <= 1'b0;
            r_over      <= '0;
            r_settle    <= '0;
            r_loud      <= '0;
            r_quiet     <= '0;
            r_level     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_phase  <= n_phase;
            r_flag   <= n_flag;
            r_dir    <= n_dir;
            r_over   <= n_over;
            r_settle <= n_settle;
            r_loud   <= n_loud;
            r_quiet  <= n_quiet;
            r_level  <= n_level;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out.mode_command <= n_cmd;
            r_out.search_phase <= n_phase;
            r_out.searching    <= n_flag;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_level <= SIL_W'(100);
            r_loud_time     <= CNT_W'(1000);
            r_silence_time  <= QUIET_W'(50);
            r_settle_ticks  <= CNT_W'(100);
            r_overdo_ignore <= CNT_W'(3);
            r_overdo_near   <= CNT_W'(1);
            r_overdo_max    <= CNT_W'(1000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SILENCE_LEVEL: r_silence_level <= i_cfg_data[SIL_W-1:0];
                REG_LOUD_TIME:     r_loud_time     <= i_cfg_data;
                REG_SILENCE_TIME:  r_silence_time  <= i_cfg_data[QUIET_W-1:0];
                REG_SETTLE_TICKS:  r_settle_ticks  <= i_cfg_data;
                REG_OVERDO_IGNORE: r_overdo_ignore <= i_cfg_data;
                REG_OVERDO_NEAR:   r_overdo_near   <= i_cfg_data;
                REG_OVERDO_MAX:    r_overdo_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/tpsc_checker.sv @@
// Port-level checks for the tape pause-search controller, bound to the top level.
module tpsc_checker import tpsc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // Nothing is offered right after a reset edge
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Play ends the search and returns to idle
    a_play_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.mode_command == CMD_PLAY
        |-> !o_out_item.searching && o_out_item.search_phase == PH_IDLE)
        else $error("play issued without ending the search");

    // Stop enters overshoot counting (the search flag may already be down);
    // winding keeps the search on and enters reverse
    a_cmd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.mode_command == CMD_STOP
            || o_out_item.mode_command == CMD_REWIND
            || o_out_item.mode_command == CMD_FORWARD)
        |-> (o_out_item.mode_command == CMD_STOP
                 && o_out_item.search_phase == PH_COUNT)
             || (o_out_item.mode_command != CMD_STOP
                 && o_out_item.searching
                 && o_out_item.search_phase == PH_REVERSE))
        else $error("command does not match phase");

endmodule

bind tape_pause_search_controller tpsc_checker u_tpsc_checker (.*);

@@ tb/tb_tape_pause_search_controller.sv @@
// Self-checking testbench for the tape pause-search controller.
`timescale 1ns / 1ps

module tb_tape_pause_search_controller;
    import tpsc_pkg::*;

    localparam int ADC_MAX = (1 << ADC_BITS) - 1;
    // First op code with no meaning; it and the two above it are ignored
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tape_pause_search_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Local copy of the configuration registers
    logic [SIL_W-1:0]   cfg_sil;
    logic [CNT_W-1:0]   cfg_loud;
    logic [QUIET_W-1:0] cfg_quiet;
    logic [CNT_W-1:0]   cfg_settle;
    logic [CNT_W-1:0]   cfg_ignore;
    logic [CNT_W-1:0]   cfg_near;
    logic [CNT_W-1:0]   cfg_max;

    // Local copy of the search state
    t_phase             ph;
    logic               search_on;
    logic               dir_rev;
    logic [CNT_W-1:0]   overshoot;
    logic [CNT_W-1:0]   settle_cnt;
    logic [CNT_W-1:0]   loud_cnt;
    logic [QUIET_W-1:0] quiet_cnt;
    logic [FL_W-1:0]    level_q;

    t_in_item  pending_events_q[$];
    t_out_item expected_status_q[$];
    t_out_item want_status;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    int queued_events = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int settings_loaded = 0;
    int fail_count = 0;
    int stop_cmds = 0;
    int play_cmds = 0;
    int wind_cmds = 0;

    // Next status of the sequencer for one accepted request
    function automatic t_out_item advance_search(input t_in_item req);
        t_cmd              cmd;
        t_out_item         status;
        logic [FL_W-1:0]   x;
        logic [FL_W-1:0]   mag;
        logic [GAIN_W-1:0] gain;
        logic [31:0]       stepv;
        logic              up;
        logic [ADC_BITS-1:0] lvl;
        logic              steady;
        cmd = CMD_NONE;
        case (req.op)
            OP_TICK: begin
                if (!search_on) begin
                    ph = PH_IDLE;
                end else begin
                    case (ph)
                        PH_IDLE: begin
                            settle_cnt = '0;
                            overshoot = '0;
                            ph = PH_FIND;
                        end
                        PH_COUNT: begin
                            if (settle_cnt != '1) settle_cnt++;
                            if (settle_cnt > cfg_settle) ph = PH_DECIDE;
                        end
                        PH_DECIDE: begin
                            if (overshoot <= cfg_ignore) begin
                                search_on = 1'b0;
                                ph = PH_IDLE;
                                cmd = CMD_PLAY;
                            end else begin
                                ph = PH_REVERSE;
                                cmd = dir_rev ? CMD_FORWARD : CMD_REWIND;
                            end
                        end
                        PH_REVERSE: begin
                            if (overshoot <= cfg_near) begin
                                search_on = 1'b0;
                                ph = PH_IDLE;
                                cmd = CMD_PLAY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_SAMPLE: begin
                if (ph != PH_FIND) begin
                    loud_cnt = '0;
                    quiet_cnt = '0;
                end else begin
                    // adaptive low-pass: fast gain on big moves, slow near the level
                    x = {req.adc_value, {FRAC_BITS{1'b0}}};
                    up = x >= level_q;
                    mag = up ? x - level_q : level_q - x;
                    gain = ((mag >> FRAC_BITS) >= 2) ? GAIN_FAST : GAIN_SLOW;
                    stepv = (32'(mag) * 32'(gain) + (32'd1 << (GAIN_W - 1))) >> GAIN_W;
                    level_q = up ? level_q + stepv[FL_W-1:0] : level_q - stepv[FL_W-1:0];
                    lvl = level_q[FL_W-1:FRAC_BITS];
                    steady = loud_cnt > cfg_loud;
                    if (lvl < cfg_sil && !steady) begin
                        quiet_cnt = '0;
                        loud_cnt = '0;
                    end else if (lvl > cfg_sil && !steady) begin
                        if (loud_cnt != '1) loud_cnt++;
                    end else if (lvl < cfg_sil && steady && quiet_cnt < cfg_quiet) begin
                        quiet_cnt++;
                    end else if (quiet_cnt >= cfg_quiet) begin
                        loud_cnt = '0;
                        quiet_cnt = '0;
                        ph = PH_COUNT;
                        cmd = CMD_STOP;
                    end
                end
            end
            OP_PULSE: begin
                if (ph == PH_COUNT && overshoot < cfg_max) overshoot++;
                if (ph == PH_REVERSE && overshoot != '0) overshoot--;
            end
            OP_START: begin
                search_on = 1'b1;
                dir_rev = req.search_reverse;
            end
            OP_CANCEL: search_on = 1'b0;
            default: ;
        endcase
        status.mode_command = cmd;
        status.search_phase = ph;
        status.searching = search_on;
        return status;
    endfunction

    // Request driver: offers queued events, holds a stalled request steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            cfg_sil = SIL_W'(100);
            cfg_loud = CNT_W'(1000);
            cfg_quiet = QUIET_W'(50);
            cfg_settle = CNT_W'(100);
            cfg_ignore = CNT_W'(3);
            cfg_near = CNT_W'(1);
            cfg_max = CNT_W'(1000);
            ph = PH_IDLE;
            search_on = 1'b0;
            dir_rev = 1'b0;
            overshoot = '0;
            settle_cnt = '0;
            loud_cnt = '0;
            quiet_cnt = '0;
            level_q = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_status_q.push_back(advance_search(i_in_item));
                requests_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item <= pending_events_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= 300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compares each result with the oldest expected status
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_status_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: result with nothing expected: cmd %0d phase %0d srch %0b",
                                 o_out_item.mode_command, o_out_item.search_phase,
                                 o_out_item.searching);
                end else begin
                    want_status = expected_status_q.pop_front();
                    if (want_status.mode_command !== o_out_item.mode_command ||
                        want_status.search_phase !== o_out_item.search_phase ||
                        want_status.searching !== o_out_item.searching) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: result %0d: expected cmd %0d phase %0d srch %0b, %s",
                                     results_seen, want_status.mode_command,
                                     want_status.search_phase, want_status.searching,
                                     $sformatf("got cmd %0d phase %0d srch %0b",
                                               o_out_item.mode_command,
                                               o_out_item.search_phase,
                                               o_out_item.searching));
                    end
                end
                case (o_out_item.mode_command)
                    CMD_STOP: stop_cmds++;
                    CMD_PLAY: play_cmds++;
                    CMD_REWIND, CMD_FORWARD: wind_cmds++;
                    default: ;
                endcase
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_event(input logic [2:0] op, input int adc, input int rev);
        t_in_item ev;
        ev.op = op;
        ev.adc_value = ADC_BITS'(adc);
        ev.search_reverse = rev[0];
        pending_events_q.push_back(ev);
        queued_events++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SILENCE_LEVEL: cfg_sil = SIL_W'(val);
            REG_LOUD_TIME:     cfg_loud = CNT_W'(val);
            REG_SILENCE_TIME:  cfg_quiet = QUIET_W'(val);
            REG_SETTLE_TICKS:  cfg_settle = CNT_W'(val);
            REG_OVERDO_IGNORE: cfg_ignore = CNT_W'(val);
            REG_OVERDO_NEAR:   cfg_near = CNT_W'(val);
            REG_OVERDO_MAX:    cfg_max = CNT_W'(val);
            default: ;
        endcase
    endtask

    task automatic load_settings(input int sil, input int loud, input int quiet,
                                 input int settle, input int ign, input int near_cnt,
                                 input int mx);
        write_reg(REG_SILENCE_LEVEL, sil);
        write_reg(REG_LOUD_TIME, loud);
        write_reg(REG_SILENCE_TIME, quiet);
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_OVERDO_IGNORE, ign);
        write_reg(REG_OVERDO_NEAR, near_cnt);
        write_reg(REG_OVERDO_MAX, mx);
        settings_loaded++;
    endtask

    task automatic set_flow(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Sender waits until the block has answered every request
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_events_q.size() != 0 || i_in_valid || expected_status_q.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // One well-formed search: start, loud stretch, silence, overshoot, decision, wind back
    task automatic queue_search_run();
        int lo;
        int hi;
        int hover;
        int n_over;
        int n_left;
        int n_settle;
        int n_ticks;
        lo = int'(cfg_sil) + (ADC_MAX - int'(cfg_sil)) / 2 + 1;
        if (lo > ADC_MAX) lo = ADC_MAX;
        hi = int'(cfg_sil) / 2;
        push_event(OP_START, $urandom_range(ADC_MAX), $urandom_range(1));
        push_event(OP_TICK, $urandom_range(ADC_MAX), $urandom_range(1));
        // some samples hover at the threshold so the level lands on it now and then
        for (int i = 0; i < int'(cfg_loud) + 6; i++) begin
            if ($urandom_range(9) == 0) begin
                hover = int'(cfg_sil) + int'($urandom_range(4)) - 2;
                if (hover < 0) hover = 0;
                if (hover > ADC_MAX) hover = ADC_MAX;
                push_event(OP_SAMPLE, hover, $urandom_range(1));
            end else begin
                push_event(OP_SAMPLE, $urandom_range(ADC_MAX, lo), $urandom_range(1));
            end
        end
        for (int i = 0; i < int'(cfg_quiet) + 6; i++)
            push_event(OP_SAMPLE, $urandom_range(hi), $urandom_range(1));
        // overshoot pulses mixed into the settle ticks
        n_over = $urandom_range(12);
        n_left = n_over;
        n_settle = int'(cfg_settle) + 1;
        while (n_left + n_settle > 0) begin
            if (n_settle == 0 || (n_left > 0 && $urandom_range(1))) begin
                push_event(OP_PULSE, $urandom_range(ADC_MAX), $urandom_range(1));
                n_left--;
            end else begin
                push_event(OP_TICK, $urandom_range(ADC_MAX), $urandom_range(1));
                n_settle--;
            end
        end
        push_event(OP_TICK, $urandom_range(ADC_MAX), $urandom_range(1));
        // winding back: pulses use up the overshoot, ticks test for near zero
        n_left = n_over + 1;
        n_ticks = n_over / 2 + 2;
        while (n_left + n_ticks > 0) begin
            if (n_ticks == 0 || (n_left > 0 && $urandom_range(1))) begin
                push_event(OP_PULSE, $urandom_range(ADC_MAX), $urandom_range(1));
                n_left--;
            end else begin
                push_event(OP_TICK, $urandom_range(ADC_MAX), $urandom_range(1));
                n_ticks--;
            end
        end
        push_event(OP_TICK, $urandom_range(ADC_MAX), $urandom_range(1));
        if ($urandom_range(99) < 40) begin
            push_event(OP_CANCEL, $urandom_range(ADC_MAX), $urandom_range(1));
            push_event(OP_TICK, $urandom_range(ADC_MAX), $urandom_range(1));
        end
    endtask

    // Mostly whole searches, with bursts of random events in between
    task automatic queue_random_traffic(input int n_events);
        int first;
        first = queued_events;
        while (queued_events - first < n_events) begin
            if ($urandom_range(99) < 80) begin
                queue_search_run();
            end else begin
                repeat ($urandom_range(4, 1))
                    push_event(3'($urandom_range(7)), $urandom_range(ADC_MAX),
                               $urandom_range(1));
            end
        end
    endtask

    // Stimulus sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at the reset settings
        push_event(OP_RESERVED_LO, ADC_MAX, 1);
        push_event(OP_RESERVED_LO + 3'd1, 0, 0);
        push_event(OP_RESERVED_LO + 3'd2, 682, 1);
        push_event(OP_SAMPLE, ADC_MAX, 0);      // sample while idle
        push_event(OP_PULSE, 0, 0);
        push_event(OP_TICK, 0, 0);              // tick with no search
        push_event(OP_CANCEL, 0, 0);
        push_event(OP_START, 0, 1);
        push_event(OP_START, 341, 0);           // start again while searching
        push_event(OP_TICK, 0, 0);
        push_event(OP_SAMPLE, 112, 0);          // first filtered level equals the threshold
        push_event(OP_SAMPLE, ADC_MAX, 1);
        push_event(OP_SAMPLE, 0, 0);
        push_event(OP_PULSE, 0, 0);
        push_event(OP_START, 0, 1);
        push_event(OP_TICK, 0, 0);
        push_event(OP_CANCEL, 0, 0);
        push_event(OP_SAMPLE, 500, 0);          // flag down, phase still looking
        push_event(OP_TICK, 0, 0);
        wait_quiet();

        // small settings, full throughput, then a long receiver hold-off
        load_settings(100, 3, 2, 4, 1, 0, 5);
        set_flow(0, 0);
        queue_random_traffic(230);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        wait_quiet();

        // random settings under each flow-control mix
        for (int mode = 1; mode < 4; mode++) begin
            load_settings($urandom_range(900, 20), $urandom_range(10), $urandom_range(6),
                          $urandom_range(8), $urandom_range(5), $urandom_range(3),
                          $urandom_range(12, 1));
            case (mode)
                1: set_flow(73, 0);
                2: set_flow(0, 73);
                default: set_flow(32, 32);
            endcase
            queue_random_traffic(230);
            wait_quiet();
        end

        // register extremes
        load_settings(0, 0, 0, 0, 0, 0, 0);
        set_flow(0, 73);
        queue_random_traffic(75);
        wait_quiet();
        load_settings(ADC_MAX, 0, 0, 0, 65535, 65535, 65535);
        set_flow(73, 0);
        queue_random_traffic(75);
        wait_quiet();
        load_settings(300, 0, 0, 0, 65535, 0, 65535);
        set_flow(32, 32);
        queue_random_traffic(75);
        wait_quiet();
        load_settings(300, 1, 1, 2, 0, 65535, 65535);
        set_flow(0, 0);
        queue_random_traffic(75);
        wait_quiet();

        repeat (4) @(posedge i_clk);
        fail_count += expected_status_q.size();
        if (fail_count > 10)
            $display("%0d further mismatches not shown", fail_count - 10);
        $display("Ran %0d requests through %0d register settings and four flow-control mixes,",
                 requests_sent, settings_loaded);
        $display("seeing %0d stop, %0d play and %0d wind-back commands in %0d results.",
                 stop_cmds, play_cmds, wind_cmds, results_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("ERROR: timeout, %0d results still expected", expected_status_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
